>>> sv/stt_pkg.sv
// Package for the source text tokenizer: token kinds, result record, shared helpers.
package stt_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;

  // Result queue: room for two beats from one byte plus slack for one-per-cycle flow.
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  localparam logic [39:0] KW_LET   = 40'h00_00_6C_65_74;  // "let"
  localparam logic [39:0] KW_PRINT = 40'h70_72_69_6E_74;  // "print"

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [3:0] {
    KIND_NUMBER  = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_LET     = 4'd2,
    KIND_PRINT   = 4'd3,
    KIND_PLUS    = 4'd4,
    KIND_MINUS   = 4'd5,
    KIND_STAR    = 4'd6,
    KIND_SLASH   = 4'd7,
    KIND_EQUAL   = 4'd8,
    KIND_LPAREN  = 4'd9,
    KIND_RPAREN  = 4'd10,
    KIND_SEMI    = 4'd11,
    KIND_UNKNOWN = 4'd12,
    KIND_EOF     = 4'd13
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  uchar;
    logic        last;
  } tok_t;

  // Up to two result beats produced by one accepted input beat.
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  typedef struct packed {
    logic [RESQ_CNT_W-1:0] level;
    logic                  room2;
  } resq_stat_t;

  function automatic logic [15:0] clamp16(logic [31:0] v);
    return (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic tok_kind_t op_kind(logic [7:0] c);
    tok_kind_t k;
    case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3D:   k = KIND_EQUAL;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3B:   k = KIND_SEMI;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

>>> sv/stt_lexer.sv
// Scanner state and token building for one byte per cycle while accept is high.
module stt_lexer #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_byte,
  input  logic          end_marker,
  output stt_pkg::push_t push
);
  import stt_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT
  } mode_t;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [OFFSET_BITS-1:0] pend_start, pend_start_next;
  logic [OFFSET_BITS-1:0] pend_len, pend_len_next;
  logic [LINE_BITS-1:0]   pend_line, pend_line_next;
  logic [39:0]            kw_prefix, kw_prefix_next;

  logic                   is_digit, is_alpha, is_space;
  logic                   flush_valid;
  tok_kind_t              flush_kind;
  tok_t                   flush_tok, byte_tok;
  logic                   byte_tok_valid;
  logic [OFFSET_BITS-1:0] offset_inc, len_inc;
  logic [LINE_BITS-1:0]   line_inc;

  assign is_digit = char_byte inside {[8'h30:8'h39]};
  assign is_alpha = char_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_space = char_byte inside {CH_SPACE, CH_TAB, CH_CR};

  assign offset_inc = (byte_offset == '1) ? byte_offset : byte_offset + OFFSET_BITS'(1);
  assign len_inc    = (pend_len == '1) ? pend_len : pend_len + OFFSET_BITS'(1);
  assign line_inc   = (line_count == '1) ? line_count : line_count + LINE_BITS'(1);

  always_comb begin
    flush_valid = 1'b1;
    flush_kind  = KIND_NUMBER;
    case (mode)
      MODE_IDLE: begin
        flush_valid = 1'b0;
      end
      MODE_NUM: begin
        flush_kind = KIND_NUMBER;
      end
      MODE_IDENT: begin
        if (pend_len == OFFSET_BITS'(3) && kw_prefix == KW_LET) begin
          flush_kind = KIND_LET;
        end else if (pend_len == OFFSET_BITS'(5) && kw_prefix == KW_PRINT) begin
          flush_kind = KIND_PRINT;
        end else begin
          flush_kind = KIND_IDENT;
        end
      end
      default: begin
        flush_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    flush_tok.kind   = flush_kind;
    flush_tok.line   = clamp16(32'(pend_line));
    flush_tok.start  = clamp16(32'(pend_start));
    flush_tok.length = clamp16(32'(pend_len));
    flush_tok.uchar  = 8'h00;
    flush_tok.last   = 1'b0;

    byte_tok.line  = clamp16(32'(line_count));
    byte_tok.start = clamp16(32'(byte_offset));
    byte_tok.last  = 1'b0;
    if (end_marker) begin
      byte_tok.kind   = KIND_EOF;
      byte_tok.length = 16'd0;
      byte_tok.uchar  = 8'h00;
    end else begin
      byte_tok.kind   = op_kind(char_byte);
      byte_tok.length = 16'd1;
      byte_tok.uchar  = (op_kind(char_byte) == KIND_UNKNOWN) ? char_byte : 8'h00;
    end
  end

  always_comb begin
    mode_next        = mode;
    byte_offset_next = byte_offset;
    line_count_next  = line_count;
    pend_start_next  = pend_start;
    pend_len_next    = pend_len;
    pend_line_next   = pend_line;
    kw_prefix_next   = kw_prefix;
    byte_tok_valid   = 1'b0;
    push.count       = 2'd0;
    push.first       = flush_tok;
    push.second      = byte_tok;

    if (end_marker) begin
      // Flush whatever is pending, then close the source with an eof beat.
      byte_tok_valid   = 1'b1;
      mode_next        = MODE_IDLE;
      byte_offset_next = '0;
      line_count_next  = LINE_BITS'(1);
      if (flush_valid) begin
        pend_len_next  = '0;
        kw_prefix_next = '0;
      end
    end else if ((mode == MODE_NUM && is_digit) ||
                 (mode == MODE_IDENT && (is_alpha || is_digit || char_byte == CH_UNDER))) begin
      // Extend the pending run; only the first five bytes feed the keyword match.
      if (mode == MODE_IDENT && pend_len < OFFSET_BITS'(5)) begin
        kw_prefix_next = {kw_prefix[31:0], char_byte};
      end
      pend_len_next    = len_inc;
      byte_offset_next = offset_inc;
    end else begin
      if (flush_valid) begin
        mode_next      = MODE_IDLE;
        pend_len_next  = '0;
        kw_prefix_next = '0;
      end
      if (char_byte == CH_LF) begin
        line_count_next = line_inc;
      end else if (is_space) begin
        // skip
      end else if (is_digit || is_alpha || char_byte == CH_UNDER) begin
        mode_next       = is_digit ? MODE_NUM : MODE_IDENT;
        pend_start_next = byte_offset;
        pend_line_next  = line_count;
        pend_len_next   = OFFSET_BITS'(1);
        kw_prefix_next  = {32'd0, char_byte};
      end else begin
        byte_tok_valid = 1'b1;
      end
      byte_offset_next = offset_inc;
    end

    if (!end_marker && !byte_tok_valid && !flush_valid) begin
      push.count = 2'd0;
    end else if (flush_valid && !(mode == MODE_NUM && is_digit && !end_marker) &&
                 !(mode == MODE_IDENT && !end_marker &&
                   (is_alpha || is_digit || char_byte == CH_UNDER))) begin
      push.count      = byte_tok_valid ? 2'd2 : 2'd1;
      push.first.last = !byte_tok_valid;
      push.second.last = 1'b1;
    end else if (byte_tok_valid) begin
      push.count       = 2'd1;
      push.first       = byte_tok;
      push.first.last  = 1'b1;
      push.second.last = 1'b1;
    end else begin
      push.count = 2'd0;
    end

    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      byte_offset <= '0;
      line_count  <= LINE_BITS'(1);
      pend_start  <= '0;
      pend_len    <= '0;
      pend_line   <= LINE_BITS'(1);
      kw_prefix   <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      byte_offset <= byte_offset_next;
      line_count  <= line_count_next;
      pend_start  <= pend_start_next;
      pend_len    <= pend_len_next;
      pend_line   <= pend_line_next;
      kw_prefix   <= kw_prefix_next;
    end
  end

endmodule

>>> sv/stt_resq.sv
// Small result queue: takes up to two token beats a cycle, hands out one.
module stt_resq (
  input  logic                 clk,
  input  logic                 rst,
  input  stt_pkg::push_t       push,
  input  logic                 pop,
  output stt_pkg::tok_t        head,
  output stt_pkg::resq_stat_t  stat
);
  import stt_pkg::*;

  tok_t                  entries [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RESQ_CNT_W-1:0] level;
  logic [RESQ_PTR_W-1:0] wr_ptr_1;

  assign wr_ptr_1   = wr_ptr + RESQ_PTR_W'(1);
  assign head       = entries[rd_ptr];
  assign stat.level = level;
  assign stat.room2 = level <= RESQ_CNT_W'(RESQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RESQ_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + RESQ_PTR_W'(1);
      end
      level <= level + RESQ_CNT_W'(push.count) - RESQ_CNT_W'(pop);
    end
  end

endmodule

>>> sv/source_text_tokenizer.sv
// Top level of the source text tokenizer: byte channel in, token channel out.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | sink      | in_valid/in_stall  | char_byte, end_marker
//   out     | source    | out_valid/out_stall| token_kind, token_line, token_start,
//           |           |                    | token_length, unknown_char, last_of_run
//
// One byte is taken per cycle unless in_stall is high; scanner state updates at the accepting edge and the
// resulting token beats land in a four-entry result queue, visible on the next cycle.
// A byte that ends a pending run and is itself a token gives two beats; such bytes cannot follow
// each other, and the queue drains one per cycle while out_stall is low, so only out_stall stalls input.
// in_stall rises whenever the queue could not absorb two more beats.
// rst is synchronous: scanner returns to idle, offset 0, line 1; queue empties.
module source_text_tokenizer #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_marker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_line,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [7:0]  unknown_char,
  output logic        last_of_run
);
  import stt_pkg::*;

  logic       in_accept;
  logic       pop;
  push_t      push;
  tok_t       head;
  resq_stat_t qstat;

  // Hold input whenever the queue lacks room for a two-beat byte.
  assign in_stall  = !qstat.room2;
  assign in_accept = in_valid && !in_stall;

  stt_lexer #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .char_byte (char_byte),
    .end_marker(end_marker),
    .push      (push)
  );

  // Advance the read side on every completed output beat.
  assign out_valid = qstat.level != '0;
  assign pop       = out_valid && !out_stall;

  stt_resq u_resq (
    .clk (clk),
    .rst (rst),
    .push(push),
    .pop (pop),
    .head(head),
    .stat(qstat)
  );

  assign token_kind   = head.kind;
  assign token_line   = head.line;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign unknown_char = head.uchar;
  assign last_of_run  = head.last;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= RESQ_CNT_W'(RESQ_DEPTH))
    else $error("result queue overfilled");

  a_eof_queued: assert property (@(posedge clk) disable iff (rst)
    (in_accept && end_marker) |=> out_valid)
    else $error("end marker produced no beat");

  a_partner_queued: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> (qstat.level >= RESQ_CNT_W'(2)))
    else $error("non-final beat without its partner in the queue");
`endif

endmodule

>>> verif/tb_top.sv
// Testbench for source_text_tokenizer: directed table followed by random byte streams.
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT} scan_t;

  // One row of the directed plan; typed rows carry their token spelled out by hand.
  typedef struct {
    logic [7:0] c;
    logic       e;
    bit         typed;
    tok_t       want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_byte;
  logic        end_marker;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  unknown_char;
  logic        last_of_run;

  source_text_tokenizer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_byte    (char_byte),
    .end_marker   (end_marker),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_start  (token_start),
    .token_length (token_length),
    .unknown_char (unknown_char),
    .last_of_run  (last_of_run)
  );

  // 12 ns period, two delays.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle rates in percent, changed per phase by the main sequence.
  int unsigned src_idle_pct = 32;
  int unsigned snk_idle_pct = 79;

  int unsigned cycle_cnt   = 0;
  int unsigned mismatches  = 0;
  int unsigned tokens_seen = 0;

  // Tokens still owed by the block, oldest first.
  tok_t token_q[$];

  // Scanner shadow state.
  scan_t       mode;
  logic [15:0] offs;
  logic [15:0] line_no;
  logic [15:0] p_start;
  logic [15:0] p_len;
  logic [15:0] p_line;
  logic [39:0] kw;

  // Tokens produced by the beat just accepted.
  tok_t fresh [0:1];
  int   fresh_n;

  // Directed plan, plus the hand-typed token the next beat must produce.
  stim_row_t plan[$];
  bit        use_typed = 1'b0;
  tok_t      typed_tok;

  string op_chars = "+-*/=();";
  string vocab [0:8] = '{"let", "print", "le", "lett", "prin", "printx", "LET", "Print",
                         "pri_nt"};

  tok_t rx_want;

  // ---------------------------------------------------------------------------
  // Shadow scanner
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic emit(tok_kind_t k, logic [15:0] ln, logic [15:0] st, logic [15:0] len,
                      logic [7:0] uch);
    fresh[fresh_n].kind   = k;
    fresh[fresh_n].line   = ln;
    fresh[fresh_n].start  = st;
    fresh[fresh_n].length = len;
    fresh[fresh_n].uchar  = uch;
    fresh[fresh_n].last   = 1'b0;
    fresh_n++;
  endtask

  // Emit the pending number or word, if any, and go idle.
  task automatic close_run();
    tok_kind_t k;
    if (mode != SCAN_IDLE) begin
      k = KIND_NUMBER;
      if (mode == SCAN_IDENT) begin
        k = KIND_IDENT;
        if (p_len == 16'd3 && kw == KW_LET) begin
          k = KIND_LET;
        end else if (p_len == 16'd5 && kw == KW_PRINT) begin
          k = KIND_PRINT;
        end
      end
      emit(k, p_line, p_start, p_len, 8'd0);
      mode  = SCAN_IDLE;
      p_len = 16'd0;
      kw    = 40'd0;
    end
  endtask

  task automatic open_run(scan_t m, logic [7:0] c);
    mode    = m;
    p_start = offs;
    p_line  = line_no;
    p_len   = 16'd1;
    kw      = {32'd0, c};
  endtask

  // Advance the shadow scanner by one accepted beat; fills fresh[].
  task automatic scan_beat(logic [7:0] c, logic e);
    int        i;
    tok_kind_t k;
    logic [7:0] uch;
    fresh_n = 0;
    if (e) begin
      // End of source: flush, report eof at the current position, restart.
      close_run();
      emit(KIND_EOF, line_no, offs, 16'd0, 8'd0);
      offs    = 16'd0;
      line_no = 16'd1;
      mode    = SCAN_IDLE;
    end else if (mode == SCAN_NUM && is_digit(c)) begin
      p_len = bump(p_len);
      offs  = bump(offs);
    end else if (mode == SCAN_IDENT && (is_alpha(c) || is_digit(c) || c == CH_UNDER)) begin
      // Keep only the first five bytes for keyword matching.
      if (p_len < 16'd5) begin
        kw = {kw[31:0], c};
      end
      p_len = bump(p_len);
      offs  = bump(offs);
    end else begin
      // The byte breaks any pending run, then stands on its own.
      close_run();
      if (c == CH_LF) begin
        line_no = bump(line_no);
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        // whitespace: nothing to emit
      end else if (is_digit(c)) begin
        open_run(SCAN_NUM, c);
      end else if (is_alpha(c) || c == CH_UNDER) begin
        open_run(SCAN_IDENT, c);
      end else begin
        k   = KIND_UNKNOWN;
        uch = c;
        for (i = 0; i < 8; i++) begin
          if (op_chars[i] == c) begin
            k   = tok_kind_t'(KIND_PLUS + i);
            uch = 8'd0;
          end
        end
        emit(k, line_no, offs, 16'd1, uch);
      end
      offs = bump(offs);
    end
    if (fresh_n > 0) begin
      fresh[fresh_n - 1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte side: drive at the falling edge, detect acceptance at the rising edge
  // ---------------------------------------------------------------------------

  // Offer one beat after a random idle gap; hold it until taken, then log its tokens.
  // Entered and left at a falling edge.
  task automatic send_beat(logic [7:0] c, logic e);
    int i;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    char_byte  <= c;
    end_marker <= e;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    scan_beat(c, e);
    if (use_typed) begin
      token_q = {token_q, typed_tok};
    end else begin
      for (i = 0; i < fresh_n; i++) begin
        token_q = {token_q, fresh[i]};
      end
    end
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0);
    end
  endtask

  // Drop valid and hold off until every owed token has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (token_q.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Byte mix biased toward real tokens: digit and word runs, operators, whitespace,
  // with a share of arbitrary bytes as noise.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    string ws;
    ws = " \t\r\n";
    r  = $urandom_range(0, 99);
    if (r < 22) return 8'("0" + $urandom_range(0, 9));
    if (r < 44) return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                            : 8'("A" + $urandom_range(0, 25));
    if (r < 48) return CH_UNDER;
    if (r < 64) return op_chars[$urandom_range(0, 7)];
    if (r < 80) return ws[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random(int unsigned n_beats, int unsigned src_pct, int unsigned snk_pct);
    int unsigned sent;
    int unsigned r;
    string w;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_beats) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // keyword or near-keyword spelled out
        w = vocab[$urandom_range(0, 8)];
        send_text(w);
        sent += w.len();
      end else if (r < 10) begin
        // end of source; the byte lane carries junk
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end else begin
        send_beat(pick_byte(), 1'b0);
        sent++;
      end
    end
  endtask

  task automatic add_row(logic [7:0] c, logic e);
    stim_row_t row;
    row.c     = c;
    row.e     = e;
    row.typed = 1'b0;
    row.want  = '0;
    plan = {plan, row};
  endtask

  task automatic add_typed(logic [7:0] c, logic e, tok_kind_t k, logic [15:0] ln,
                           logic [15:0] st, logic [15:0] len, logic [7:0] uch);
    stim_row_t row;
    row.c           = c;
    row.e           = e;
    row.typed       = 1'b1;
    row.want.kind   = k;
    row.want.line   = ln;
    row.want.start  = st;
    row.want.length = len;
    row.want.uchar  = uch;
    row.want.last   = 1'b1;
    plan = {plan, row};
  endtask

  task automatic add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      add_row(s[i], 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Token side: random stall at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  task automatic flag(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch on token %0d: %s got %0d want %0d", tokens_seen, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag(what, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        flag("unexpected token, kind", 32'(token_kind), 32'd0);
      end else begin
        rx_want = token_q.pop_front();
        check_field("kind",   32'(token_kind),   32'(rx_want.kind));
        check_field("line",   32'(token_line),   32'(rx_want.line));
        check_field("start",  32'(token_start),  32'(rx_want.start));
        check_field("length", 32'(token_length), 32'(rx_want.length));
        check_field("uchar",  32'(unknown_char), 32'(rx_want.uchar));
        check_field("last",   32'(last_of_run),  32'(rx_want.last));
      end
      tokens_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    rst        = 1'b1;
    in_valid   = 1'b0;
    char_byte  = 8'd0;
    end_marker = 1'b0;
    out_stall  = 1'b0;

    mode    = SCAN_IDLE;
    offs    = 16'd0;
    line_no = 16'd1;
    p_start = 16'd0;
    p_len   = 16'd0;
    p_line  = 16'd1;
    kw      = 40'd0;

    // Directed plan. The first rows carry hand-typed tokens: eof right
    // after reset, the lowest and highest bytes as unknowns, a lone operator.
    add_typed(8'h00, 1'b1, KIND_EOF,     16'd1, 16'd0, 16'd0, 8'h00);
    add_typed(8'h00, 1'b0, KIND_UNKNOWN, 16'd1, 16'd0, 16'd1, 8'h00);
    add_typed(8'hFF, 1'b0, KIND_UNKNOWN, 16'd1, 16'd1, 16'd1, 8'hFF);
    add_typed("+",   1'b0, KIND_PLUS,    16'd1, 16'd2, 16'd1, 8'h00);
    // Runs cut short by operators (two tokens per byte), both keywords, every
    // operator but plus, a high byte, then end of source with a word still pending.
    add_text("9-let*print/(x);");
    add_row(8'h80, 1'b0);
    add_text("=_9");
    add_row(8'h5A, 1'b1);

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase A: sender idles 32%, receiver 79%.
    src_idle_pct = 32;
    snk_idle_pct = 79;
    for (i = 0; i < plan.size(); i++) begin
      use_typed = plan[i].typed;
      typed_tok = plan[i].want;
      send_beat(plan[i].c, plan[i].e);
    end
    use_typed = 1'b0;
    run_random(620, 32, 79);

    // Let the block empty out completely before switching the idle pattern.
    drain();

    // Phase B: roles swapped.
    run_random(620, 79, 32);
    drain();

    // Phase C: full rate both ways.
    run_random(610, 0, 0);

    // Close the source: a digit, then the end marker.
    send_beat("7", 1'b0);
    send_beat(8'h00, 1'b1);
    drain();

    // Watch a little longer for stray tokens.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/stt_pkg.sv
sv/stt_lexer.sv
sv/stt_resq.sv
sv/source_text_tokenizer.sv
verif/tb_top.sv
